// ----- hdl/tts_pkg.sv -----
`default_nettype none

package tts_pkg;

  localparam int TASKS     = 4;
  localparam int TIME_BITS = 48;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIME_STEP     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WD_ENABLE     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WD_BOUND      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TASK_COUNT    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TASK_PERIOD_0 = 3'd4;

  localparam logic [9:0] TIME_STEP_RESET = 10'd1;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_POLL = 2'd1,
    MODE_ARM  = 2'd2,
    MODE_KICK = 2'd3
  } mode_t;

  typedef struct packed {
    logic [9:0]             time_step;
    logic                   wd_enable;
    logic [31:0]            wd_bound;
    logic [2:0]             task_count;
    logic [TASKS-1:0][31:0] task_period;
  } tts_cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  task_success;
    logic        watchdog_ok;
    logic [31:0] delay_ms;
  } tts_item_t;

  typedef struct packed {
    logic [47:0] now_time;
    logic [3:0]  due_mask;
    logic        delayed_fire;
    logic        watchdog_hit;
    logic        timeout_flag;
  } tts_result_t;

endpackage

`default_nettype wire

// ----- hdl/tick_task_scheduler_watchdog.sv -----
// Millisecond tick scheduler with periodic task table, one-shot delayed
// event and watchdog timer.
// Input channel (in_valid / in_stall) carries one item: mode selects tick,
// poll, arm or kick; task_success, watchdog_ok and delay_ms go with it.
// Output channel (out_valid / out_stall) returns exactly one result per
// item: current time, due mask, delayed fire, watchdog hit, timeout flag.
// An input transfer lands in an input register; from there the scheduler
// state is updated and the result is loaded into the output register, so
// throughput is one item per cycle while out_stall is low.
// The rate is set by the single update of the time, task, delay and watchdog
// state per item, which all fits between the two registers.
// While out_stall holds a waiting result, one more item is still taken
// into the input register; in_stall rises only when both registers are full.
// Configuration (cfg_write / cfg_index / cfg_data) writes one register per
// cycle and should only be used while no item is in flight.
// Synchronous reset clears time, task last-run times, watchdog timer,
// timeout flag and delayed event, empties both registers and restores the
// configuration defaults (time step 1, everything else 0).
`default_nettype none

module tick_task_scheduler_watchdog
  import tts_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                mode,
  input  wire logic [3:0]                task_success,
  input  wire logic                      watchdog_ok,
  input  wire logic [31:0]               delay_ms,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [47:0]                    now_time,
  output logic [3:0]                     due_mask,
  output logic                           delayed_fire,
  output logic                           watchdog_hit,
  output logic                           timeout_flag,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  tts_cfg_t    cfg;
  tts_item_t   item;
  tts_result_t result;
  logic        item_valid;
  logic        advance;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = item_valid && !advance;

  tts_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tts_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .go     (item_valid && advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.mode         <= mode_t'(mode);
      item.task_success <= task_success;
      item.watchdog_ok  <= watchdog_ok;
      item.delay_ms     <= delay_ms;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      now_time     <= result.now_time;
      due_mask     <= result.due_mask;
      delayed_fire <= result.delayed_fire;
      watchdog_hit <= result.watchdog_hit;
      timeout_flag <= result.timeout_flag;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("input stalled while a register is free");

  a_hit_sets_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && watchdog_hit |-> timeout_flag)
    else $error("watchdog hit without timeout flag");

  a_hit_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && watchdog_hit |-> due_mask == 4'd0 && !delayed_fire)
    else $error("watchdog hit together with poll results");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> item_valid && $stable(item))
    else $error("held item changed while stalled");

endmodule

`default_nettype wire

// ----- hdl/tts_cfg_regs.sv -----
`default_nettype none

module tts_cfg_regs
  import tts_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output tts_cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step   <= TIME_STEP_RESET;
      cfg.wd_enable   <= 1'b0;
      cfg.wd_bound    <= '0;
      cfg.task_count  <= '0;
      cfg.task_period <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TIME_STEP:  cfg.time_step  <= cfg_data[9:0];
        CFG_WD_ENABLE:  cfg.wd_enable  <= cfg_data[0];
        CFG_WD_BOUND:   cfg.wd_bound   <= cfg_data[31:0];
        CFG_TASK_COUNT: cfg.task_count <= cfg_data[2:0];
        default: begin
          for (int t = 0; t < TASKS; t++) begin
            if (cfg_index == CFG_INDEX_BITS'(int'(CFG_TASK_PERIOD_0) + t)) begin
              cfg.task_period[t] <= cfg_data[31:0];
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tts_engine.sv -----
`default_nettype none

module tts_engine
  import tts_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  go,
  input  tts_item_t  item,
  input  tts_cfg_t   cfg,
  output tts_result_t result
);

  logic [TIME_BITS-1:0] time_now, time_now_next;
  logic [TIME_BITS-1:0] task_last_run [TASKS];
  logic [TIME_BITS-1:0] task_last_run_next [TASKS];
  logic [31:0]          watchdog_count, watchdog_count_next;
  logic                 timeout_seen, timeout_seen_next;
  logic [TIME_BITS-1:0] delay_start, delay_start_next;
  logic [31:0]          delay_left, delay_left_next;

  logic [TIME_BITS-1:0] task_limit [TASKS];
  logic [TIME_BITS-1:0] delay_limit;
  logic [TIME_BITS-1:0] time_sum;
  logic [31:0]          wd_sum;
  logic [2:0]           used;
  logic [TASKS-1:0]     due;
  logic                 fire;
  logic                 hit;

  always_comb begin
    for (int t = 0; t < TASKS; t++) begin
      task_limit[t] = task_last_run[t] + TIME_BITS'(cfg.task_period[t]);
    end
    delay_limit = delay_start + TIME_BITS'(delay_left);
    time_sum    = time_now + TIME_BITS'(cfg.time_step);
    wd_sum      = watchdog_count + 32'(cfg.time_step);
    used        = (cfg.task_count > 3'(TASKS)) ? 3'(TASKS) : cfg.task_count;
  end

  always_comb begin
    time_now_next       = time_now;
    task_last_run_next  = task_last_run;
    watchdog_count_next = watchdog_count;
    timeout_seen_next   = timeout_seen;
    delay_start_next    = delay_start;
    delay_left_next     = delay_left;
    due                 = '0;
    fire                = 1'b0;
    hit                 = 1'b0;
    case (item.mode)
      MODE_TICK: begin
        time_now_next = time_sum;
        if (cfg.wd_enable) begin
          watchdog_count_next = wd_sum;
          if (wd_sum >= cfg.wd_bound) begin
            hit               = 1'b1;
            timeout_seen_next = 1'b1;
            if (item.watchdog_ok) begin
              watchdog_count_next = '0;
            end
          end
        end
      end
      MODE_POLL: begin
        for (int t = 0; t < TASKS; t++) begin
          if (3'(t) < used && time_now >= task_limit[t]) begin
            due[t] = 1'b1;
            if (item.task_success[t]) begin
              task_last_run_next[t] = time_now;
            end
          end
        end
        if (delay_left != '0 && time_now >= delay_limit) begin
          fire            = 1'b1;
          delay_left_next = '0;
        end
      end
      MODE_ARM: begin
        delay_start_next = time_now;
        delay_left_next  = item.delay_ms;
      end
      MODE_KICK: begin
        watchdog_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.now_time     = 48'(time_now_next);
    result.due_mask     = 4'(due);
    result.delayed_fire = fire;
    result.watchdog_hit = hit;
    result.timeout_flag = timeout_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now       <= '0;
      watchdog_count <= '0;
      timeout_seen   <= 1'b0;
      delay_start    <= '0;
      delay_left     <= '0;
      for (int t = 0; t < TASKS; t++) begin
        task_last_run[t] <= '0;
      end
    end else if (go) begin
      time_now       <= time_now_next;
      task_last_run  <= task_last_run_next;
      watchdog_count <= watchdog_count_next;
      timeout_seen   <= timeout_seen_next;
      delay_start    <= delay_start_next;
      delay_left     <= delay_left_next;
    end
  end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import tts_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                mode = MODE_TICK;
  logic [3:0]                task_success = '0;
  logic                      watchdog_ok = 1'b0;
  logic [31:0]               delay_ms = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [47:0]               now_time;
  logic [3:0]                due_mask;
  logic                      delayed_fire;
  logic                      watchdog_hit;
  logic                      timeout_flag;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  tick_task_scheduler_watchdog dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .task_success (task_success),
    .watchdog_ok  (watchdog_ok),
    .delay_ms     (delay_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .now_time     (now_time),
    .due_mask     (due_mask),
    .delayed_fire (delayed_fire),
    .watchdog_hit (watchdog_hit),
    .timeout_flag (timeout_flag),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // scheduler configuration copy
  logic [9:0]  step_cfg;
  logic        wd_en_cfg;
  logic [31:0] wd_bound_cfg;
  logic [2:0]  task_count_cfg;
  logic [31:0] period_cfg [TASKS];

  // scheduler state copy
  logic [47:0] time_ms;
  logic [47:0] last_run [TASKS];
  logic [31:0] wd_timer;
  logic        timeout_seen;
  logic [47:0] delay_start;
  logic [31:0] delay_left;

  tts_item_t   item_q [$];
  tts_result_t sched_results_q [$];
  tts_item_t   cur_item;
  tts_result_t exp_res;
  tts_result_t want;

  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int results_seen = 0;
  int next_hold_at = 500;
  int errors = 0;
  int idle_odds = 8;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic schedule_step(input tts_item_t it, output tts_result_t res);
    logic [47:0] limit;
    int used;
    int i;
    res = '0;
    case (it.mode)
      MODE_TICK: begin
        time_ms = time_ms + {38'd0, step_cfg};
        if (wd_en_cfg) begin
          wd_timer = wd_timer + {22'd0, step_cfg};
          if (wd_timer >= wd_bound_cfg) begin
            res.watchdog_hit = 1'b1;
            timeout_seen = 1'b1;
            if (it.watchdog_ok) wd_timer = '0;
          end
        end
      end
      MODE_POLL: begin
        used = (task_count_cfg > TASKS) ? TASKS : task_count_cfg;
        for (i = 0; i < used; i++) begin
          limit = last_run[i] + {16'd0, period_cfg[i]};
          if (time_ms >= limit) begin
            res.due_mask[i] = 1'b1;
            if (it.task_success[i]) last_run[i] = time_ms;
          end
        end
        if (delay_left != '0) begin
          limit = delay_start + {16'd0, delay_left};
          if (time_ms >= limit) begin
            res.delayed_fire = 1'b1;
            delay_left = '0;
          end
        end
      end
      MODE_ARM: begin
        delay_start = time_ms;
        delay_left = it.delay_ms;
      end
      default: wd_timer = '0;
    endcase
    res.now_time = time_ms;
    res.timeout_flag = timeout_seen;
  endtask

  task automatic report_mismatch(input string msg);
    if (errors < 50) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic wait_idle;
    do @(negedge clk);
    while (item_q.size() != 0 || in_valid || sched_results_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_TIME_STEP:  step_cfg = val[9:0];
      CFG_WD_ENABLE:  wd_en_cfg = val[0];
      CFG_WD_BOUND:   wd_bound_cfg = val;
      CFG_TASK_COUNT: task_count_cfg = val[2:0];
      default:        period_cfg[idx - CFG_TASK_PERIOD_0] = val;
    endcase
  endtask

  task automatic load_config(input tts_cfg_t c);
    logic [31:0] junk;
    logic [CFG_INDEX_BITS-1:0] idx;
    wait_idle;
    // upper data bits beyond each register width must be dropped
    junk = $urandom;
    write_reg(CFG_TIME_STEP, {junk[31:10], c.time_step});
    write_reg(CFG_WD_ENABLE, {junk[31:1], c.wd_enable});
    write_reg(CFG_WD_BOUND, c.wd_bound);
    write_reg(CFG_TASK_COUNT, {junk[31:3], c.task_count});
    idx = CFG_TASK_PERIOD_0;
    repeat (TASKS) begin
      write_reg(idx, c.task_period[idx - CFG_TASK_PERIOD_0]);
      idx++;
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic void push_item(input mode_t m, input logic [3:0] s, input logic ok,
                                    input logic [31:0] d);
    tts_item_t it;
    it.mode = m;
    it.task_success = s;
    it.watchdog_ok = ok;
    it.delay_ms = d;
    item_q.push_back(it);
  endfunction

  function automatic tts_item_t random_item(input int step);
    tts_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) it.mode = MODE_TICK;
    else if (r < 75) it.mode = MODE_POLL;
    else if (r < 87) it.mode = MODE_ARM;
    else it.mode = MODE_KICK;
    it.task_success = 4'($urandom);
    it.watchdog_ok = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 7))
      0:       it.delay_ms = '0;
      1:       it.delay_ms = $urandom;
      default: it.delay_ms = $urandom_range(1, step * 30 + 1);
    endcase
    return it;
  endfunction

  // input side driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        schedule_step(cur_item, exp_res);
        sched_results_q.push_back(exp_res);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (item_q.size() > 0 && idle_odds != 0 &&
                     $urandom_range(1, idle_odds) == 1) begin
          send_gap = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (item_q.size() > 0) begin
          cur_item = item_q.pop_front();
          in_valid <= 1'b1;
          mode <= cur_item.mode;
          task_success <= cur_item.task_success;
          watchdog_ok <= cur_item.watchdog_ok;
          delay_ms <= cur_item.delay_ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side monitor and stall generator
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sched_results_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = sched_results_q.pop_front();
          if (now_time !== want.now_time)
            report_mismatch($sformatf("now_time %0d, expected %0d", now_time, want.now_time));
          if (due_mask !== want.due_mask)
            report_mismatch($sformatf("due_mask %b, expected %b", due_mask, want.due_mask));
          if (delayed_fire !== want.delayed_fire)
            report_mismatch($sformatf("delayed_fire %b, expected %b", delayed_fire,
                                      want.delayed_fire));
          if (watchdog_hit !== want.watchdog_hit)
            report_mismatch($sformatf("watchdog_hit %b, expected %b", watchdog_hit,
                                      want.watchdog_hit));
          if (timeout_flag !== want.timeout_flag)
            report_mismatch($sformatf("timeout_flag %b, expected %b", timeout_flag,
                                      want.timeout_flag));
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= next_hold_at) begin
        // long hold-off so both pipeline registers fill and the input stalls
        next_hold_at += 700;
        hold_left = 199;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        recv_gap = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    tts_cfg_t c;
    int p;
    int n;
    int s;
    int k;
    step_cfg = TIME_STEP_RESET;
    wd_en_cfg = 1'b0;
    wd_bound_cfg = '0;
    task_count_cfg = '0;
    time_ms = '0;
    wd_timer = '0;
    timeout_seen = 1'b0;
    delay_start = '0;
    delay_left = '0;
    for (k = 0; k < TASKS; k++) begin
      period_cfg[k] = '0;
      last_run[k] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: no tasks in use, watchdog off
    push_item(MODE_TICK, 4'hF, 1'b1, 32'hFFFF_FFFF);
    push_item(MODE_POLL, 4'hF, 1'b0, 32'h0);
    push_item(MODE_ARM, 4'h0, 1'b0, 32'hFFFF_FFFF);
    push_item(MODE_KICK, 4'h0, 1'b1, 32'h0);

    // zero step, zero bound, task count above table size
    c.time_step = 10'd0;
    c.wd_enable = 1'b1;
    c.wd_bound = 32'd0;
    c.task_count = 3'd7;
    c.task_period = {32'd0, 32'd3, 32'hFFFF_FFFF, 32'd0};  // entries 3..0
    load_config(c);
    push_item(MODE_TICK, 4'h0, 1'b0, 32'h0);
    push_item(MODE_TICK, 4'h0, 1'b1, 32'h0);
    push_item(MODE_POLL, 4'h0, 1'b0, 32'h0);
    push_item(MODE_POLL, 4'hF, 1'b0, 32'h0);
    push_item(MODE_ARM, 4'h0, 1'b0, 32'h0);
    push_item(MODE_POLL, 4'hF, 1'b0, 32'h0);
    push_item(MODE_KICK, 4'h0, 1'b0, 32'h0);

    // large step, timeout with and without restart, rearm and one-shot fire
    c.time_step = 10'd1000;
    c.wd_enable = 1'b1;
    c.wd_bound = 32'd2500;
    c.task_count = 3'd2;
    c.task_period = {32'd1, 32'd1, 32'd1000, 32'd2000};
    load_config(c);
    push_item(MODE_ARM, 4'h0, 1'b0, 32'd1500);
    push_item(MODE_TICK, 4'h0, 1'b0, 32'h0);
    push_item(MODE_POLL, 4'b1101, 1'b0, 32'h0);
    push_item(MODE_ARM, 4'h0, 1'b0, 32'd3000);
    push_item(MODE_TICK, 4'h0, 1'b0, 32'h0);
    push_item(MODE_TICK, 4'h0, 1'b0, 32'h0);
    push_item(MODE_TICK, 4'h0, 1'b1, 32'h0);
    push_item(MODE_POLL, 4'hF, 1'b0, 32'h0);
    push_item(MODE_POLL, 4'hF, 1'b0, 32'h0);
    push_item(MODE_KICK, 4'h0, 1'b0, 32'h0);
    push_item(MODE_TICK, 4'hF, 1'b1, 32'h0);

    for (p = 0; p < 8; p++) begin
      case (p)
        0:       c.time_step = 10'd1;
        1:       c.time_step = 10'd1000;
        2:       c.time_step = 10'd0;
        default: c.time_step = 10'($urandom_range(1, 1000));
      endcase
      s = c.time_step;
      c.wd_enable = (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      if (p == 1) c.wd_bound = 32'hFFFF_FFFF;
      else if (p == 2) c.wd_bound = 32'd0;
      else c.wd_bound = $urandom_range(0, s * 20 + 1);
      c.task_count = 3'(p % 8);
      for (k = 0; k < TASKS; k++) begin
        case ($urandom_range(0, 7))
          0:       c.task_period[k] = 32'd0;
          1:       c.task_period[k] = 32'hFFFF_FFFF;
          default: c.task_period[k] = $urandom_range(0, s * 12 + 1);
        endcase
      end
      load_config(c);
      if (p == 7) idle_odds = 0;
      else if (p % 3 == 0) idle_odds = 30;
      else idle_odds = 6;
      for (n = 0; n < 228; n++) item_q.push_back(random_item(s));
    end

    wait_idle;
    repeat (10) @(posedge clk);
    if (sched_results_q.size() != 0) report_mismatch("results still expected at end of run");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
